### hw/rtl/char_lcd_i2c_nibble_sequencer_assert.svh
// ---------------------------------------------------------------------------
// char lcd i2c sequencer assertion macros
// implication checks, same cycle and next cycle, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_I2C_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_I2C_NIBBLE_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LCDI2C_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LCDI2C_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LCDI2C_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCDI2C_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/lcdi2c_pkg.sv
// ---------------------------------------------------------------------------
// lcdi2c_pkg
// shared types, codes and constants of the char lcd i2c sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcdi2c_pkg;

  localparam int ROWS_DEF = 4;
  localparam int COLS_DEF = 20;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] INIT_NIB_STEPS = 4'd4;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd8;

  localparam logic [7:0] SIG_BACKLIGHT = 8'h08;

  localparam logic [14:0] DLY_POWERUP = 15'd20000;
  localparam logic [12:0] DLY_WAKE1   = 13'd5000;
  localparam logic [12:0] DLY_WAKE2   = 13'd200;
  localparam logic [12:0] DLY_LONG    = 13'd2000;
  localparam logic [12:0] DLY_SHORT   = 13'd40;

  typedef enum logic [3:0] {
    OP_DATA    = 4'd0,
    OP_RAW     = 4'd1,
    OP_CLEAR   = 4'd2,
    OP_HOME    = 4'd3,
    OP_DISPLAY = 4'd4,
    OP_ENTRY   = 4'd5,
    OP_FUNC    = 4'd6,
    OP_CURSOR  = 4'd7,
    OP_INIT    = 4'd8
  } op_t;

  typedef enum logic [3:0] {
    CFG_DEV_ADDR  = 4'd0,
    CFG_INIT_FUNC = 4'd1,
    CFG_INIT_DISP = 4'd2,
    CFG_INIT_ENTR = 4'd3
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic              load;
    logic              emit;
    logic [STEP_W-1:0] step;
    logic [1:0]        phase;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic in_op_ok;
    logic is_init;
    logic out_free;
  } status_t;

  function automatic logic [6:0] row_base(input logic [1:0] r);
    logic [6:0] b;
    case (r)
      2'd0: b = 7'h00;
      2'd1: b = 7'h40;
      2'd2: b = 7'h14;
      default: b = 7'h54;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lcdi2c_ctrl.sv
// ---------------------------------------------------------------------------
// lcdi2c_ctrl
// sequencer fsm: walks the byte and nibble steps of one operation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_i2c_nibble_sequencer_assert.svh"

module lcdi2c_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  lcdi2c_pkg::status_t  st,
  output lcdi2c_pkg::cmd_t     cmd
);

  lcdi2c_pkg::state_t state_r, state_nxt;
  logic [lcdi2c_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic nib_step;
  logic step_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcdi2c_pkg::ST_IDLE;
      step_r  <= '0;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    in_ready  = 1'b0;
    nib_step  = st.is_init && (step_r < lcdi2c_pkg::INIT_NIB_STEPS);
    step_end  = nib_step ? phase_r[0] : (phase_r == 2'd3);
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.step  = step_r;
    cmd.phase = phase_r;
    cmd.last  = step_end && (!st.is_init || step_r == lcdi2c_pkg::INIT_LAST_STEP);
    case (state_r)
      lcdi2c_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && st.in_op_ok) begin
          cmd.load  = 1'b1;
          state_nxt = lcdi2c_pkg::ST_RUN;
          step_nxt  = '0;
          phase_nxt = '0;
        end
      end
      lcdi2c_pkg::ST_RUN: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (cmd.last) begin
            state_nxt = lcdi2c_pkg::ST_IDLE;
          end else if (step_end) begin
            step_nxt  = step_r + 1'b1;
            phase_nxt = '0;
          end else begin
            phase_nxt = phase_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = lcdi2c_pkg::ST_IDLE;
      end
    endcase
  end

  `LCDI2C_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, st.out_free)
  `LCDI2C_ASSERT_NXT(a_last_idle, clk, rst_n, cmd.emit && cmd.last, state_r == lcdi2c_pkg::ST_IDLE)
  `LCDI2C_ASSERT_NXT(a_load_start, clk, rst_n, cmd.load,
    state_r == lcdi2c_pkg::ST_RUN && step_r == '0 && phase_r == '0)

endmodule

`default_nettype wire

### hw/rtl/lcdi2c_dp.sv
// ---------------------------------------------------------------------------
// lcdi2c_dp
// datapath: config registers, item latch, byte build and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdi2c_dp #(
  parameter int ROWS = lcdi2c_pkg::ROWS_DEF,
  parameter int COLS = lcdi2c_pkg::COLS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_valid,
  input  wire  [3:0]           cfg_index,
  input  wire  [7:0]           cfg_data,
  input  wire  [3:0]           in_op,
  input  wire  [7:0]           in_value,
  input  wire  [7:0]           in_row,
  input  wire  [7:0]           in_col,
  input  lcdi2c_pkg::cmd_t     cmd,
  output lcdi2c_pkg::status_t  st,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [7:0]           out_bus_address_byte,
  output logic [7:0]           out_expander_byte,
  output logic [14:0]          out_delay_before_us,
  output logic [12:0]          out_delay_after_us,
  output logic                 out_last
);

  logic [6:0] dev_addr_r;
  logic [4:0] init_func_r;
  logic [2:0] init_disp_r;
  logic [1:0] init_entr_r;

  logic        is_init_r;
  logic        rs_r;
  logic [7:0]  byte_r;
  logic [12:0] after_r;

  logic        out_valid_r;
  logic [7:0]  addr_out_r;
  logic [7:0]  exp_out_r;
  logic [14:0] before_out_r;
  logic [12:0] after_out_r;
  logic        last_out_r;

  logic [7:0]  byte_nxt;
  logic [12:0] after_nxt;
  logic [7:0]  row_c;
  logic [7:0]  col_c;
  logic [6:0]  cur_addr;

  logic        nib_step;
  logic        step_end;
  logic [7:0]  step_byte;
  logic [12:0] step_after;
  logic [3:0]  nib;
  logic [7:0]  exp_nxt;
  logic [12:0] dly_after_nxt;
  logic [14:0] dly_before_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= 7'd39;
      init_func_r <= 5'd8;
      init_disp_r <= 3'd4;
      init_entr_r <= 2'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        lcdi2c_pkg::CFG_DEV_ADDR:  dev_addr_r  <= cfg_data[6:0];
        lcdi2c_pkg::CFG_INIT_FUNC: init_func_r <= cfg_data[4:0];
        lcdi2c_pkg::CFG_INIT_DISP: init_disp_r <= cfg_data[2:0];
        lcdi2c_pkg::CFG_INIT_ENTR: init_entr_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // byte and post delay of a single-byte operation
  always_comb begin
    row_c    = (in_row > 8'(ROWS - 1)) ? 8'(ROWS - 1) : in_row;
    col_c    = (in_col > 8'(COLS - 1)) ? 8'(COLS - 1) : in_col;
    cur_addr = 7'(lcdi2c_pkg::row_base(row_c[1:0]) + col_c[6:0]);
    byte_nxt  = in_value;
    after_nxt = '0;
    case (in_op)
      lcdi2c_pkg::OP_DATA: byte_nxt = in_value;
      lcdi2c_pkg::OP_RAW:  byte_nxt = in_value;
      lcdi2c_pkg::OP_CLEAR: begin
        byte_nxt  = 8'h01;
        after_nxt = lcdi2c_pkg::DLY_LONG;
      end
      lcdi2c_pkg::OP_HOME: begin
        byte_nxt  = 8'h02;
        after_nxt = lcdi2c_pkg::DLY_LONG;
      end
      lcdi2c_pkg::OP_DISPLAY: begin
        byte_nxt  = 8'h08 | (in_value & 8'h07);
        after_nxt = lcdi2c_pkg::DLY_SHORT;
      end
      lcdi2c_pkg::OP_ENTRY: begin
        byte_nxt  = 8'h04 | (in_value & 8'h03);
        after_nxt = lcdi2c_pkg::DLY_SHORT;
      end
      lcdi2c_pkg::OP_FUNC: begin
        byte_nxt  = 8'h20 | (in_value & 8'h1C);
        after_nxt = lcdi2c_pkg::DLY_SHORT;
      end
      lcdi2c_pkg::OP_CURSOR: begin
        byte_nxt  = {1'b1, cur_addr};
        after_nxt = lcdi2c_pkg::DLY_SHORT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_init_r <= 1'b0;
    end else if (cmd.load) begin
      is_init_r <= (in_op == lcdi2c_pkg::OP_INIT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rs_r    <= (in_op == lcdi2c_pkg::OP_DATA);
      byte_r  <= byte_nxt;
      after_r <= after_nxt;
    end
  end

  // transfer build for the current step and phase
  always_comb begin
    nib_step   = is_init_r && (cmd.step < lcdi2c_pkg::INIT_NIB_STEPS);
    step_end   = nib_step ? cmd.phase[0] : (cmd.phase == 2'd3);
    step_byte  = byte_r;
    step_after = after_r;
    if (is_init_r) begin
      case (cmd.step)
        4'd4: begin
          step_byte  = 8'h20 | {3'b000, init_func_r & 5'h1C};
          step_after = lcdi2c_pkg::DLY_SHORT;
        end
        4'd5: begin
          step_byte  = 8'h08 | {5'b00000, init_disp_r};
          step_after = lcdi2c_pkg::DLY_SHORT;
        end
        4'd6: begin
          step_byte  = 8'h04 | {6'b000000, init_entr_r};
          step_after = lcdi2c_pkg::DLY_SHORT;
        end
        4'd7: begin
          step_byte  = 8'h01;
          step_after = lcdi2c_pkg::DLY_LONG;
        end
        4'd8: begin
          step_byte  = 8'h02;
          step_after = lcdi2c_pkg::DLY_LONG;
        end
        4'd0: step_after = lcdi2c_pkg::DLY_WAKE1;
        4'd1: step_after = lcdi2c_pkg::DLY_WAKE2;
        default: step_after = '0;
      endcase
    end
    if (nib_step) begin
      nib = (cmd.step == 4'd3) ? 4'h2 : 4'h3;
    end else if (cmd.phase[1]) begin
      nib = step_byte[3:0];
    end else begin
      nib = step_byte[7:4];
    end
    exp_nxt = {nib, 4'b0000} | lcdi2c_pkg::SIG_BACKLIGHT
              | {5'b00000, ~cmd.phase[0], 1'b0, rs_r && !is_init_r};
    dly_after_nxt  = step_end ? step_after : '0;
    dly_before_nxt = (is_init_r && cmd.step == '0 && cmd.phase == '0)
                     ? lcdi2c_pkg::DLY_POWERUP : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      addr_out_r   <= {dev_addr_r, 1'b0};
      exp_out_r    <= exp_nxt;
      before_out_r <= dly_before_nxt;
      after_out_r  <= dly_after_nxt;
      last_out_r   <= cmd.last;
    end
  end

  assign st.in_op_ok = (in_op <= lcdi2c_pkg::OP_INIT);
  assign st.is_init  = is_init_r;
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_bus_address_byte = addr_out_r;
  assign out_expander_byte    = exp_out_r;
  assign out_delay_before_us  = before_out_r;
  assign out_delay_after_us   = after_out_r;
  assign out_last             = last_out_r;

endmodule

`default_nettype wire

### hw/rtl/char_lcd_i2c_nibble_sequencer.sv
// ---------------------------------------------------------------------------
// char_lcd_i2c_nibble_sequencer
// turns one character lcd operation into 4-bit expander write transfers
//
// channel  direction  payload
// in       sink       op, value, row, col
// out      source     bus_address_byte, expander_byte, delays, last
// cfg      sink       index, data (always ready)
//
// an operation is taken while the fsm is idle, then one transfer leaves per
// cycle while the out channel is free; the step fsm sets the sequence
// unknown op codes are accepted and give no transfer
// a stalled out channel holds the fsm; the next op is taken once the last
// transfer sits in the output register
// synchronous active-low reset restores the config registers
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_i2c_nibble_sequencer #(
  parameter int ROWS = lcdi2c_pkg::ROWS_DEF,
  parameter int COLS = lcdi2c_pkg::COLS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [3:0]  cfg_index,
  input  wire  [7:0]  cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [3:0]  in_op,
  input  wire  [7:0]  in_value,
  input  wire  [7:0]  in_row,
  input  wire  [7:0]  in_col,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_bus_address_byte,
  output logic [7:0]  out_expander_byte,
  output logic [14:0] out_delay_before_us,
  output logic [12:0] out_delay_after_us,
  output logic        out_last
);

  lcdi2c_pkg::cmd_t    cmd;
  lcdi2c_pkg::status_t st;

  assign cfg_ready = 1'b1;

  lcdi2c_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lcdi2c_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_op                (in_op),
    .in_value             (in_value),
    .in_row               (in_row),
    .in_col               (in_col),
    .cmd                  (cmd),
    .st                   (st),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_bus_address_byte (out_bus_address_byte),
    .out_expander_byte    (out_expander_byte),
    .out_delay_before_us  (out_delay_before_us),
    .out_delay_after_us   (out_delay_after_us),
    .out_last             (out_last)
  );

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: char lcd i2c nibble sequencer
// drives lcd operations and register writes through valid/ready channels,
// predicts every expander write transfer from a local copy of the registers
// and checks the out channel field by field under random idling on both sides
// ----------------------------------------------------------------------------
module tb;

  localparam int DISP_ROWS = 4;
  localparam int DISP_COLS = 20;

  localparam logic [7:0] PIN_BACKLIGHT = 8'h08;
  localparam logic [7:0] PIN_ENABLE    = 8'h04;
  localparam logic [7:0] PIN_RS        = 8'h01;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_ENTRY    = 8'h04;
  localparam logic [7:0] CMD_DISPLAY  = 8'h08;
  localparam logic [7:0] CMD_FUNCTION = 8'h20;
  localparam logic [7:0] CMD_DDRAM    = 8'h80;

  localparam logic [7:0] MASK_ENTRY    = 8'h03;
  localparam logic [7:0] MASK_DISPLAY  = 8'h07;
  localparam logic [7:0] MASK_FUNCTION = 8'h1C;

  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;

  localparam logic [14:0] US_POWERUP = 15'd20000;
  localparam logic [12:0] US_WAKE1   = 13'd5000;
  localparam logic [12:0] US_WAKE2   = 13'd200;
  localparam logic [12:0] US_LONG    = 13'd2000;
  localparam logic [12:0] US_SHORT   = 13'd40;

  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam logic [3:0] CFG_IDX_UNUSED_LO = 4'd4;
  localparam logic [3:0] CFG_IDX_UNUSED_HI = 4'd15;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_ERR_LINES  = 30;

  typedef struct packed {
    logic [7:0]  addr_byte;
    logic [7:0]  lcd_byte;
    logic [14:0] pre_us;
    logic [12:0] post_us;
    logic        last;
  } lcd_xfer_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_op = '0;
  logic [7:0]  in_value = '0;
  logic [7:0]  in_row = '0;
  logic [7:0]  in_col = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [7:0]  out_bus_address_byte;
  logic [7:0]  out_expander_byte;
  logic [14:0] out_delay_before_us;
  logic [12:0] out_delay_after_us;
  logic        out_last;

  // register copies
  logic [6:0] dev_addr_q   = 7'd39;
  logic [4:0] init_func_q  = 5'd8;
  logic [2:0] init_disp_q  = 3'd4;
  logic [1:0] init_entry_q = 2'd2;

  lcd_xfer_t lcd_xfers_due[$];

  logic in_gap_en    = 1'b0;
  logic out_stall_en = 1'b0;
  int   out_hold     = 0;
  int   quiet_cycles = 0;
  int   mismatches   = 0;
  int   ops_taken    = 0;
  int   inits_taken  = 0;
  int   xfers_seen   = 0;
  int   cfg_writes   = 0;

  char_lcd_i2c_nibble_sequencer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_value             (in_value),
    .in_row               (in_row),
    .in_col               (in_col),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_bus_address_byte (out_bus_address_byte),
    .out_expander_byte    (out_expander_byte),
    .out_delay_before_us  (out_delay_before_us),
    .out_delay_after_us   (out_delay_after_us),
    .out_last             (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [6:0] ddram_row_start(input logic [1:0] r);
    logic [6:0] s;
    case (r)
      2'd0: s = 7'h00;
      2'd1: s = 7'h40;
      2'd2: s = 7'h14;
      default: s = 7'h54;
    endcase
    return s;
  endfunction

  function automatic void queue_xfer(input logic [7:0] b, input logic [14:0] pre,
                                     input logic [12:0] post);
    lcd_xfer_t x;
    x.addr_byte = {dev_addr_q, 1'b0};
    x.lcd_byte  = b;
    x.pre_us    = pre;
    x.post_us   = post;
    x.last      = 1'b0;
    lcd_xfers_due.push_back(x);
  endfunction

  function automatic void queue_nibble(input logic [3:0] nib, input logic rs,
                                       input logic [14:0] pre, input logic [12:0] post);
    logic [7:0] b;
    b = {nib, 4'h0} | PIN_BACKLIGHT | (rs ? PIN_RS : 8'h00);
    queue_xfer(b | PIN_ENABLE, pre, '0);
    queue_xfer(b & ~PIN_ENABLE, '0, post);
  endfunction

  function automatic void queue_lcd_byte(input logic [7:0] v, input logic rs,
                                         input logic [12:0] post);
    queue_nibble(v[7:4], rs, '0, '0);
    queue_nibble(v[3:0], rs, '0, post);
  endfunction

  function automatic void predict_lcd_op(input logic [3:0] op, input logic [7:0] value,
                                         input logic [7:0] row, input logic [7:0] col);
    int         n0;
    logic [7:0] r;
    logic [7:0] c;
    logic [6:0] ddram;
    n0 = lcd_xfers_due.size();
    case (op)
      lcdi2c_pkg::OP_DATA:  queue_lcd_byte(value, 1'b1, '0);
      lcdi2c_pkg::OP_RAW:   queue_lcd_byte(value, 1'b0, '0);
      lcdi2c_pkg::OP_CLEAR: queue_lcd_byte(CMD_CLEAR, 1'b0, US_LONG);
      lcdi2c_pkg::OP_HOME:  queue_lcd_byte(CMD_HOME, 1'b0, US_LONG);
      lcdi2c_pkg::OP_DISPLAY: begin
        queue_lcd_byte(CMD_DISPLAY | (value & MASK_DISPLAY), 1'b0, US_SHORT);
      end
      lcdi2c_pkg::OP_ENTRY: begin
        queue_lcd_byte(CMD_ENTRY | (value & MASK_ENTRY), 1'b0, US_SHORT);
      end
      lcdi2c_pkg::OP_FUNC: begin
        queue_lcd_byte(CMD_FUNCTION | (value & MASK_FUNCTION), 1'b0, US_SHORT);
      end
      lcdi2c_pkg::OP_CURSOR: begin
        r = (row > DISP_ROWS - 1) ? 8'(DISP_ROWS - 1) : row;
        c = (col > DISP_COLS - 1) ? 8'(DISP_COLS - 1) : col;
        ddram = ddram_row_start(r[1:0]) + c[6:0];
        queue_lcd_byte(CMD_DDRAM | {1'b0, ddram}, 1'b0, US_SHORT);
      end
      lcdi2c_pkg::OP_INIT: begin
        queue_nibble(NIB_WAKE, 1'b0, US_POWERUP, US_WAKE1);
        queue_nibble(NIB_WAKE, 1'b0, '0, US_WAKE2);
        queue_nibble(NIB_WAKE, 1'b0, '0, '0);
        queue_nibble(NIB_4BIT, 1'b0, '0, '0);
        queue_lcd_byte(CMD_FUNCTION | ({3'b0, init_func_q} & MASK_FUNCTION), 1'b0, US_SHORT);
        queue_lcd_byte(CMD_DISPLAY | {5'b0, init_disp_q}, 1'b0, US_SHORT);
        queue_lcd_byte(CMD_ENTRY | {6'b0, init_entry_q}, 1'b0, US_SHORT);
        queue_lcd_byte(CMD_CLEAR, 1'b0, US_LONG);
        queue_lcd_byte(CMD_HOME, 1'b0, US_LONG);
      end
      default: ;
    endcase
    if (lcd_xfers_due.size() > n0) lcd_xfers_due[lcd_xfers_due.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_ERR_LINES) begin
      $display("tb: mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
  endtask

  // prediction on accepted ops, checking on accepted transfers
  always @(posedge clk) begin : monitor_blk
    lcd_xfer_t due;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_lcd_op(in_op, in_value, in_row, in_col);
        ops_taken++;
        if (in_op == lcdi2c_pkg::OP_INIT) inits_taken++;
      end
      if (out_valid && out_ready) begin
        xfers_seen++;
        if (lcd_xfers_due.size() == 0) begin
          report_mismatch("unexpected transfer, expander_byte", out_expander_byte, -1);
        end else begin
          due = lcd_xfers_due.pop_front();
          if (out_bus_address_byte !== due.addr_byte)
            report_mismatch("bus_address_byte", out_bus_address_byte, due.addr_byte);
          if (out_expander_byte !== due.lcd_byte)
            report_mismatch("expander_byte", out_expander_byte, due.lcd_byte);
          if (out_delay_before_us !== due.pre_us)
            report_mismatch("delay_before_us", out_delay_before_us, due.pre_us);
          if (out_delay_after_us !== due.post_us)
            report_mismatch("delay_after_us", out_delay_after_us, due.post_us);
          if (out_last !== due.last)
            report_mismatch("last", out_last, due.last);
        end
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (!rst_n || !out_stall_en) begin
      out_ready <= 1'b1;
      out_hold  <= 0;
    end else if (out_hold != 0) begin
      out_ready <= 1'b0;
      out_hold  <= out_hold - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      out_hold  <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog, %0d transfers still due", lcd_xfers_due.size());
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_lcd_op(input logic [3:0] op, input logic [7:0] value,
                             input logic [7:0] row, input logic [7:0] col);
    int gap;
    if (in_gap_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    in_row   <= row;
    in_col   <= col;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_op();
    int         pick;
    logic [3:0] op;
    logic [7:0] row;
    logic [7:0] col;
    pick = $urandom_range(0, 99);
    if (pick < 6) op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    else if (pick < 11) op = lcdi2c_pkg::OP_INIT;
    else op = 4'($urandom_range(lcdi2c_pkg::OP_DATA, lcdi2c_pkg::OP_CURSOR));
    row = $urandom_range(0, 1) ? 8'($urandom_range(0, DISP_ROWS - 1)) : 8'($urandom_range(0, 255));
    col = $urandom_range(0, 1) ? 8'($urandom_range(0, DISP_COLS - 1)) : 8'($urandom_range(0, 255));
    send_lcd_op(op, 8'($urandom_range(0, 255)), row, col);
  endtask

  // sender holds off until every due transfer has left
  task automatic wait_all_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lcd_xfers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [3:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      lcdi2c_pkg::CFG_DEV_ADDR:  dev_addr_q   = data[6:0];
      lcdi2c_pkg::CFG_INIT_FUNC: init_func_q  = data[4:0];
      lcdi2c_pkg::CFG_INIT_DISP: init_disp_q  = data[2:0];
      lcdi2c_pkg::CFG_INIT_ENTR: init_entry_q = data[1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_lcd_op(lcdi2c_pkg::OP_INIT, 8'h00, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_DATA, 8'h41, 8'h00, 8'h00);
    wait_all_done();
  endtask

  task automatic test_each_op();
    send_lcd_op(lcdi2c_pkg::OP_DATA, 8'h00, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_DATA, 8'hFF, 8'hFF, 8'hFF);
    send_lcd_op(lcdi2c_pkg::OP_RAW, 8'hA5, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_RAW, 8'hFF, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_CLEAR, 8'hFF, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_HOME, 8'h00, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_DISPLAY, 8'hFF, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_DISPLAY, 8'h00, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_ENTRY, 8'hFF, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_ENTRY, 8'h00, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_FUNC, 8'hFF, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_FUNC, 8'h00, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_CURSOR, 8'h00, 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_CURSOR, 8'h00, 8'd3, 8'd19);
    send_lcd_op(lcdi2c_pkg::OP_CURSOR, 8'h00, 8'd4, 8'd20);
    send_lcd_op(lcdi2c_pkg::OP_CURSOR, 8'hFF, 8'hFF, 8'hFF);
    send_lcd_op(lcdi2c_pkg::OP_CURSOR, 8'h00, 8'd1, 8'd200);
    send_lcd_op(lcdi2c_pkg::OP_CURSOR, 8'h00, 8'd2, 8'd7);
    send_lcd_op(OP_UNUSED_LO, 8'h12, 8'h00, 8'h00);
    send_lcd_op(OP_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF);
    send_lcd_op(lcdi2c_pkg::OP_INIT, 8'hFF, 8'hFF, 8'hFF);
    send_lcd_op(lcdi2c_pkg::OP_DATA, 8'h5A, 8'h00, 8'h00);
    wait_all_done();
  endtask

  task automatic run_cfg_setting(input logic [7:0] addr, input logic [7:0] func,
                                 input logic [7:0] disp, input logic [7:0] entry);
    write_cfg(lcdi2c_pkg::CFG_DEV_ADDR, addr);
    write_cfg(lcdi2c_pkg::CFG_INIT_FUNC, func);
    write_cfg(lcdi2c_pkg::CFG_INIT_DISP, disp);
    write_cfg(lcdi2c_pkg::CFG_INIT_ENTR, entry);
    // out of range index, no register may change
    write_cfg(4'($urandom_range(CFG_IDX_UNUSED_LO, CFG_IDX_UNUSED_HI)),
              8'($urandom_range(0, 255)));
    send_lcd_op(lcdi2c_pkg::OP_INIT, 8'($urandom_range(0, 255)), 8'h00, 8'h00);
    send_lcd_op(lcdi2c_pkg::OP_CURSOR, 8'h00, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    repeat (6) send_random_op();
    wait_all_done();
  endtask

  task automatic test_cfg_sweep();
    in_gap_en    = 1'b1;
    out_stall_en = 1'b1;
    run_cfg_setting(8'h00, 8'h00, 8'h00, 8'h00);
    run_cfg_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_cfg_setting(8'h7F, 8'h1C, 8'h07, 8'h03);
    run_cfg_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_cfg_setting(8'd39, 8'd8, 8'd4, 8'd2);
  endtask

  task automatic test_random_ops();
    in_gap_en    = 1'b1;
    out_stall_en = 1'b1;
    for (int i = 0; i < 300; i++) begin
      send_random_op();
      if (i % 100 == 99) wait_all_done();
    end
    wait_all_done();
  endtask

  task automatic test_full_rate();
    in_gap_en    = 1'b0;
    out_stall_en = 1'b0;
    repeat (40) send_random_op();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_each_op();
    test_cfg_sweep();
    test_random_ops();
    test_full_rate();
    wait_all_done();
    $display("tb: %0d operations taken (%0d init), %0d transfers checked",
             ops_taken, inits_taken, xfers_seen);
    $display("tb: %0d register writes over 5 settings, %0d mismatches",
             cfg_writes, mismatches);
    if (mismatches == 0 && lcd_xfers_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
